/* src/kdhr_pkg.sv */
// kdhr_pkg: shared types and constants of the four-key debounce, hold and repeat block
// used by the interfaces, the key lanes, the output merge and the top level
`default_nettype none
package kdhr_pkg;

    localparam int unsigned KEY_COUNT = 4;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [7:0] KEY_PORT_MASK = 8'h33;
    localparam logic [7:0] COUNT_CEILING = 8'hFE;

    // port pin of each key: set, on, mem, hall
    localparam int unsigned KEY_PIN [KEY_COUNT] = '{0, 1, 4, 5};

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_LIMIT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_INTERVAL = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SET_HOLD_LIMIT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_HOLD_LIMIT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MEM_HOLD_LIMIT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HALL_HOLD_LIMIT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_ENABLE   = 3'd6;

    typedef struct packed {
        logic [7:0] debounce_limit;
        logic [7:0] repeat_interval;
        logic [7:0] hold_limit;
        logic       repeat_en;
    } t_lane_cfg;

    typedef struct packed {
        logic press;
        logic hold;
        logic rep;
        logic rel;
    } t_lane_flags;

    typedef struct packed {
        logic [KEY_COUNT-1:0] press_flags;
        logic [KEY_COUNT-1:0] hold_flags;
        logic [KEY_COUNT-1:0] repeat_flags;
        logic [KEY_COUNT-1:0] release_flags;
    } t_result;

    typedef struct packed {
        logic push;
        logic pop;
    } t_buf_ctrl;

endpackage
`default_nettype wire

/* src/kdhr_if.sv */
// kdhr_if: valid/ready channel interfaces for scan beats, result beats and config writes
// depends on kdhr_pkg
`default_nettype none
interface kdhr_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_port;
    logic [kdhr_pkg::KEY_COUNT-1:0] clear_release_mask;
    logic       clear_all;

    modport source (output valid, output raw_port, output clear_release_mask,
                    output clear_all, input ready);
    modport sink (input valid, input raw_port, input clear_release_mask,
                  input clear_all, output ready);
endinterface

interface kdhr_flags_if;
    logic valid;
    logic ready;
    logic [kdhr_pkg::KEY_COUNT-1:0] press_flags;
    logic [kdhr_pkg::KEY_COUNT-1:0] hold_flags;
    logic [kdhr_pkg::KEY_COUNT-1:0] repeat_flags;
    logic [kdhr_pkg::KEY_COUNT-1:0] release_flags;

    modport source (output valid, output press_flags, output hold_flags,
                    output repeat_flags, output release_flags, input ready);
    modport sink (input valid, input press_flags, input hold_flags,
                  input repeat_flags, input release_flags, output ready);
endinterface

interface kdhr_cfg_if;
    logic valid;
    logic ready;
    logic [kdhr_pkg::CFG_INDEX_W-1:0] index;
    logic [kdhr_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/key_debounce_hold_repeat.sv */
// key_debounce_hold_repeat: four-key debouncer with hold and auto-repeat detection
// a result beat enters the output buffer when its scan beat is taken and is offered once earlier beats are taken
// throughput: one scan beat per cycle while the output buffer is not full; four key lanes update in parallel
// a two-beat output buffer lets scan beats keep flowing while one result waits
// reset: synchronous, active low; all keys idle, flags cleared, registers to defaults
`default_nettype none
module key_debounce_hold_repeat (
    input  wire           i_clk,
    input  wire           i_rst_n,
    kdhr_scan_if.sink     i_scan,
    kdhr_cfg_if.sink      i_cfg,
    kdhr_flags_if.source  o_flags
);

    logic [7:0]                     r_debounce_limit;
    logic [7:0]                     r_repeat_interval;
    logic [7:0]                     r_hold_limit [kdhr_pkg::KEY_COUNT];
    logic [kdhr_pkg::KEY_COUNT-1:0] r_repeat_enable;

    logic                  scan_accept;
    logic                  can_accept;
    logic [7:0]            keys_down;
    kdhr_pkg::t_buf_ctrl   buf_ctrl;
    kdhr_pkg::t_lane_flags lane_flags [kdhr_pkg::KEY_COUNT];
    kdhr_pkg::t_result     result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_limit  <= 8'd2;
            r_repeat_interval <= 8'd10;
            for (int k = 0; k < kdhr_pkg::KEY_COUNT; k++) r_hold_limit[k] <= 8'd254;
            r_repeat_enable   <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                kdhr_pkg::REG_DEBOUNCE_LIMIT:  r_debounce_limit  <= i_cfg.data;
                kdhr_pkg::REG_REPEAT_INTERVAL: r_repeat_interval <= i_cfg.data;
                kdhr_pkg::REG_SET_HOLD_LIMIT:  r_hold_limit[0]   <= i_cfg.data;
                kdhr_pkg::REG_ON_HOLD_LIMIT:   r_hold_limit[1]   <= i_cfg.data;
                kdhr_pkg::REG_MEM_HOLD_LIMIT:  r_hold_limit[2]   <= i_cfg.data;
                kdhr_pkg::REG_HALL_HOLD_LIMIT: r_hold_limit[3]   <= i_cfg.data;
                kdhr_pkg::REG_REPEAT_ENABLE:
                    r_repeat_enable <= i_cfg.data[kdhr_pkg::KEY_COUNT-1:0];
                default: ;
            endcase
        end
    end

    assign i_scan.ready  = can_accept;
    assign scan_accept   = i_scan.valid & can_accept;
    assign keys_down     = (i_scan.raw_port & kdhr_pkg::KEY_PORT_MASK) ^ kdhr_pkg::KEY_PORT_MASK;
    assign buf_ctrl.push = scan_accept;
    assign buf_ctrl.pop  = o_flags.valid & o_flags.ready;

    for (genvar k = 0; k < kdhr_pkg::KEY_COUNT; k++) begin : g_lane
        kdhr_pkg::t_lane_cfg lane_cfg;

        assign lane_cfg.debounce_limit  = r_debounce_limit;
        assign lane_cfg.repeat_interval = r_repeat_interval;
        assign lane_cfg.hold_limit      = r_hold_limit[k];
        assign lane_cfg.repeat_en       = r_repeat_enable[k];

        kdhr_key_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_accept     (scan_accept),
            .i_down       (keys_down[kdhr_pkg::KEY_PIN[k]]),
            .i_clear_all  (i_scan.clear_all),
            .i_clear_rel  (i_scan.clear_release_mask[k]),
            .i_cfg        (lane_cfg),
            .o_next_flags (lane_flags[k])
        );
    end

    kdhr_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (buf_ctrl),
        .i_lane_flags (lane_flags),
        .o_can_accept (can_accept),
        .o_valid      (o_flags.valid),
        .o_result     (result)
    );

    assign o_flags.press_flags   = result.press_flags;
    assign o_flags.hold_flags    = result.hold_flags;
    assign o_flags.repeat_flags  = result.repeat_flags;
    assign o_flags.release_flags = result.release_flags;

endmodule
`default_nettype wire

/* src/kdhr_key_lane.sv */
// kdhr_key_lane: one key's idle/debounce/confirmed/release machine with its count and flags
// depends on kdhr_pkg
`default_nettype none
module kdhr_key_lane (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_accept,
    input  wire                     i_down,
    input  wire                     i_clear_all,
    input  wire                     i_clear_rel,
    input  kdhr_pkg::t_lane_cfg     i_cfg,
    output kdhr_pkg::t_lane_flags   o_next_flags
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DEBOUNCE,
        PH_CONFIRMED,
        PH_RELEASE
    } t_phase;

    t_phase                r_phase, n_phase, cur_phase;
    logic [7:0]            r_count, n_count, inc_count;
    logic                  r_latched, n_latched, cur_latched;
    kdhr_pkg::t_lane_flags r_flags, n_flags, cur_flags;

    always_comb begin
        // clear all first, then release acknowledge, then the scan
        cur_phase   = i_clear_all ? PH_IDLE : r_phase;
        cur_latched = i_clear_all ? 1'b0 : r_latched;
        cur_flags   = i_clear_all ? '0 : r_flags;
        cur_flags.rel = cur_flags.rel & ~i_clear_rel;

        n_phase   = cur_phase;
        n_latched = cur_latched;
        n_count   = r_count;
        n_flags   = cur_flags;
        inc_count = r_count + 8'd1;

        unique case (cur_phase)
            PH_IDLE: begin
                if (i_down) begin
                    n_count   = '0;
                    n_latched = 1'b1;
                    n_phase   = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                if (cur_latched == i_down) begin
                    n_count = inc_count;
                    if (inc_count > i_cfg.debounce_limit) begin
                        n_phase = PH_CONFIRMED;
                        if (i_down) n_flags.press = 1'b1;
                    end
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_CONFIRMED: begin
                if (cur_latched == i_down) begin
                    if (r_count < kdhr_pkg::COUNT_CEILING) n_count = inc_count;
                    if (n_count > i_cfg.hold_limit) begin
                        if (i_down) n_flags.hold = 1'b1;
                        if (i_cfg.repeat_en) begin
                            if (i_down) n_flags.rep = 1'b1;
                            n_count = i_cfg.hold_limit - i_cfg.repeat_interval;
                        end
                    end
                end else begin
                    n_phase = PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                if (!i_down) begin
                    if (cur_latched) begin
                        n_flags.press = 1'b0;
                        n_flags.hold  = 1'b0;
                        n_flags.rep   = 1'b0;
                        n_flags.rel   = 1'b1;
                    end
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_count   <= '0;
            r_latched <= 1'b0;
            r_flags   <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_latched <= n_latched;
            r_flags   <= n_flags;
        end
    end

    assign o_next_flags = n_flags;

endmodule
`default_nettype wire

/* src/kdhr_merge.sv */
// kdhr_merge: gathers the lane flags into one result and queues it in a two-beat output buffer
// depends on kdhr_pkg
`default_nettype none
module kdhr_merge (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  kdhr_pkg::t_buf_ctrl     i_ctrl,
    input  kdhr_pkg::t_lane_flags   i_lane_flags [kdhr_pkg::KEY_COUNT],
    output logic                    o_can_accept,
    output logic                    o_valid,
    output kdhr_pkg::t_result       o_result
);

    kdhr_pkg::t_result merged;
    kdhr_pkg::t_result r_head, r_tail;
    logic [1:0]        r_count;

    always_comb begin
        merged = '0;
        for (int k = 0; k < kdhr_pkg::KEY_COUNT; k++) begin
            merged.press_flags[k]   = i_lane_flags[k].press;
            merged.hold_flags[k]    = i_lane_flags[k].hold;
            merged.repeat_flags[k]  = i_lane_flags[k].rep;
            merged.release_flags[k] = i_lane_flags[k].rel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case ({i_ctrl.push, i_ctrl.pop})
                2'b10: begin
                    if (r_count == 2'd0) r_head <= merged;
                    else r_tail <= merged;
                    r_count <= r_count + 2'd1;
                end
                2'b01: begin
                    r_head  <= r_tail;
                    r_count <= r_count - 2'd1;
                end
                2'b11: begin
                    if (r_count == 2'd2) begin
                        r_head <= r_tail;
                        r_tail <= merged;
                    end else begin
                        r_head <= merged;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_can_accept = (r_count != 2'd2);
    assign o_valid      = (r_count != 2'd0);
    assign o_result     = r_head;

endmodule
`default_nettype wire

/* src/kdhr_checker.sv */
// kdhr_checker: port-level assertions on the flag relations and the output buffer
// depends on kdhr_if; bound to key_debounce_hold_repeat
`default_nettype none
module kdhr_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_scan_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [3:0] i_press,
    input wire [3:0] i_hold,
    input wire [3:0] i_repeat,
    input wire [3:0] i_release
);

    a_hold_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_hold & ~i_press) == 4'd0))
        else $error("hold flag without press flag");

    a_repeat_needs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_repeat & ~i_hold) == 4'd0))
        else $error("repeat flag without hold flag");

    a_full_means_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_scan_ready |-> i_out_valid)
        else $error("scan stalled with no result beat waiting");

    a_stalled_beat_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_press) && $stable(i_hold)
             && $stable(i_repeat) && $stable(i_release)))
        else $error("stalled result beat changed");

endmodule

bind key_debounce_hold_repeat kdhr_checker u_kdhr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_scan_ready (i_scan.ready),
    .i_out_valid  (o_flags.valid),
    .i_out_ready  (o_flags.ready),
    .i_press      (o_flags.press_flags),
    .i_hold       (o_flags.hold_flags),
    .i_repeat     (o_flags.repeat_flags),
    .i_release    (o_flags.release_flags)
);
`default_nettype wire
